// ----- hdl/linked_stereo_transient_shaper_defines.svh -----
// Assertion macros shared by the shaper modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef LINKED_STEREO_TRANSIENT_SHAPER_DEFINES_SVH
`define LINKED_STEREO_TRANSIENT_SHAPER_DEFINES_SVH

`ifndef SYNTH

`define LSTS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsts assertion failed");

`define LSTS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsts assertion failed");

`else

`define LSTS_ASSERT_IMP(name, ante, cons)

`define LSTS_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ----- hdl/lsts_pkg.sv -----
package lsts_pkg;

    localparam int SMP_W    = 24;
    localparam int ENV_W    = 32;
    localparam int GAIN_W   = 24;
    localparam int AMT_W    = 16;
    localparam int COEF_W   = 24;
    localparam int WET_W    = 17;
    localparam int CFG_W    = 24;
    localparam int CFG_IX_W = 3;
    localparam int RATIO_W  = 17;
    localparam int DES_W    = 23;
    localparam int FACT_W   = 40;
    localparam int MA_W     = 25;
    localparam int MB_W     = 32;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int ACC_W    = 64;
    localparam int DIV_STEPS = 16;
    localparam int DCNT_W   = 4;

    localparam logic [COEF_W:0]   POLE_ONE     = 25'd16777216;
    localparam logic [GAIN_W-1:0] ONE_Q20      = 24'd1048576;
    localparam logic [DES_W-1:0]  GAIN_MIN_Q20 = 23'd209715;
    localparam logic [DES_W-1:0]  GAIN_MAX_Q20 = 23'd4194304;
    localparam logic [WET_W-1:0]  WET_FULL     = 17'd65536;
    localparam logic [RATIO_W-1:0] RATIO_FULL  = 17'd65536;

    localparam logic [AMT_W-1:0]  RST_ATTACK  = 16'd16384;
    localparam logic [AMT_W-1:0]  RST_SUSTAIN = 16'd0;
    localparam logic [COEF_W-1:0] RST_FAST    = 24'd16707456;
    localparam logic [COEF_W-1:0] RST_SLOW    = 24'd16774886;
    localparam logic [COEF_W-1:0] RST_SLEW    = 24'd16431306;
    localparam logic [WET_W-1:0]  RST_WET     = 17'd65536;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_SUSTAIN = 3'd1,
        CFG_FAST    = 3'd2,
        CFG_SLOW    = 3'd3,
        CFG_SLEW    = 3'd4,
        CFG_WET     = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_FAST_OLD,
        MS_FAST_NEW,
        MS_SLOW_OLD,
        MS_SLOW_NEW,
        MS_SLEW_OLD,
        MS_SLEW_NEW,
        MS_WET,
        MS_MAG_LO,
        MS_MAG_HI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_HI
    } acc_op_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_CAPTURE,
        WB_FAST,
        WB_SLOW,
        WB_DIV_INIT,
        WB_DIV_STEP,
        WB_RATIO_SAT,
        WB_TERM,
        WB_DESIRED,
        WB_GAIN,
        WB_FACTOR,
        WB_OUT_L,
        WB_OUT_R,
        WB_PUBLISH
    } wb_t;

    typedef struct packed {
        mul_sel_t mul;
        acc_op_t  acc;
        wb_t      wb;
        logic     chan;
    } cmd_t;

    typedef struct packed {
        logic ratio_sat;
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_S1,
        S_S2,
        S_D0,
        S_DIV,
        S_T0,
        S_T1,
        S_G0,
        S_G1,
        S_G2,
        S_G3,
        S_W0,
        S_W1,
        S_L0,
        S_L1,
        S_L2,
        S_L3,
        S_R1,
        S_R2,
        S_PUB
    } state_t;

endpackage

// ----- hdl/lsts_ifs.sv -----
interface lsts_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [lsts_pkg::SMP_W-1:0] left_in;
    logic signed [lsts_pkg::SMP_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface lsts_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [lsts_pkg::SMP_W-1:0] left_out;
    logic signed [lsts_pkg::SMP_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- hdl/lsts_datapath.sv -----
`include "linked_stereo_transient_shaper_defines.svh"

module lsts_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lsts_pkg::cmd_t                       cmd,
    output lsts_pkg::status_t                    status,
    input  logic                                 cfg_we,
    input  logic [lsts_pkg::CFG_IX_W-1:0]        cfg_index,
    input  logic [lsts_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [lsts_pkg::SMP_W-1:0]    left_in,
    input  logic signed [lsts_pkg::SMP_W-1:0]    right_in,
    output logic signed [lsts_pkg::SMP_W-1:0]    left_out,
    output logic signed [lsts_pkg::SMP_W-1:0]    right_out
);

    function automatic logic [lsts_pkg::SMP_W-1:0] mag24(input logic [lsts_pkg::SMP_W-1:0] x);
        mag24 = x[lsts_pkg::SMP_W-1] ? (~x + 24'd1) : x;
    endfunction

    // Round the accumulated product to a sample and saturate by sign.
    function automatic logic [lsts_pkg::SMP_W-1:0] shape24(input logic [63:0] acc,
                                                         input logic neg);
        logic [63:0] rnd;
        logic [27:0] r;
        logic [27:0] rn;
        rnd = acc + 64'h0000_0008_0000_0000;
        r   = rnd[63:36];
        rn  = ~r + 28'd1;
        if (neg)
            shape24 = (r > 28'd8388608) ? 24'h800000 : rn[23:0];
        else
            shape24 = (r > 28'd8388607) ? 24'h7FFFFF : r[23:0];
    endfunction

    logic [lsts_pkg::AMT_W-1:0]  attack_reg, sustain_reg;
    logic [lsts_pkg::COEF_W-1:0] fast_coef_reg, slow_coef_reg, slew_coef_reg;
    logic [lsts_pkg::WET_W-1:0]  wet_reg;

    logic [lsts_pkg::ENV_W-1:0]  fast_env_reg, fast_env_next;
    logic [lsts_pkg::ENV_W-1:0]  slow_env_reg, slow_env_next;
    logic [lsts_pkg::GAIN_W-1:0] gain_reg, gain_next;

    logic                        neg_l_reg, neg_r_reg;
    logic [lsts_pkg::SMP_W-1:0]  mag_l_reg, mag_r_reg;
    logic [lsts_pkg::ENV_W-1:0]  level_reg;
    logic [lsts_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [lsts_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [lsts_pkg::ENV_W-1:0]  denom_reg;
    logic [lsts_pkg::ENV_W:0]    rem_reg;
    logic [lsts_pkg::RATIO_W-1:0] ratio_reg;
    logic                        attack_sel_reg;
    logic signed [33:0]          term_reg;
    logic [lsts_pkg::DES_W-1:0]  desired_reg, desired_next;
    logic [lsts_pkg::FACT_W-1:0] factor_reg;
    logic [lsts_pkg::SMP_W-1:0]  res_l_reg, res_r_reg, out_l_reg, out_r_reg;

    logic [lsts_pkg::MA_W-1:0]   mul_a;
    logic [lsts_pkg::MB_W-1:0]   mul_b;
    logic [lsts_pkg::SMP_W-1:0]  mag_sel;
    logic [lsts_pkg::WET_W-1:0]  wet_c;
    logic [lsts_pkg::ACC_W-1:0]  pole_rnd;
    logic [lsts_pkg::SMP_W:0]    mag_sum;
    logic [lsts_pkg::ENV_W-1:0]  env_diff;
    logic [lsts_pkg::ENV_W:0]    rem_shift;
    logic                        rem_ge;
    logic signed [34:0]          term_rnd;
    logic signed [35:0]          desired_full;
    logic [lsts_pkg::FACT_W-1:0] dry_part;

    assign mag_sel  = cmd.chan ? mag_r_reg : mag_l_reg;
    assign wet_c    = (wet_reg > lsts_pkg::WET_FULL) ? lsts_pkg::WET_FULL : wet_reg;
    assign pole_rnd = acc_reg + 64'd8388608;
    assign mag_sum  = {1'b0, mag24(left_in)} + {1'b0, mag24(right_in)};
    assign env_diff = (fast_env_reg >= slow_env_reg) ? (fast_env_reg - slow_env_reg)
                                                     : (slow_env_reg - fast_env_reg);
    assign rem_shift = {rem_reg[lsts_pkg::ENV_W-1:0], 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, denom_reg};
    assign status.ratio_sat = rem_reg >= {1'b0, denom_reg};
    assign term_rnd  = 35'(term_reg) + 35'sd1024;
    assign desired_full = 36'sd1048576 + 36'(term_rnd >>> 11);
    assign dry_part  = 40'(lsts_pkg::WET_FULL - wet_c) << 20;

    always_comb
    begin
        if (desired_full < 36'sd209715)
            desired_next = lsts_pkg::GAIN_MIN_Q20;
        else if (desired_full > 36'sd4194304)
            desired_next = lsts_pkg::GAIN_MAX_Q20;
        else
            desired_next = desired_full[lsts_pkg::DES_W-1:0];
    end

    always_comb
    begin
        case (cmd.mul)
            lsts_pkg::MS_FAST_OLD: begin mul_a = {1'b0, fast_coef_reg}; mul_b = fast_env_reg; end
            lsts_pkg::MS_FAST_NEW: begin mul_a = lsts_pkg::POLE_ONE - 25'(fast_coef_reg);
                                         mul_b = level_reg; end
            lsts_pkg::MS_SLOW_OLD: begin mul_a = {1'b0, slow_coef_reg}; mul_b = slow_env_reg; end
            lsts_pkg::MS_SLOW_NEW: begin mul_a = lsts_pkg::POLE_ONE - 25'(slow_coef_reg);
                                         mul_b = level_reg; end
            lsts_pkg::MS_SLEW_OLD: begin mul_a = {1'b0, slew_coef_reg}; mul_b = 32'(gain_reg); end
            lsts_pkg::MS_SLEW_NEW: begin mul_a = lsts_pkg::POLE_ONE - 25'(slew_coef_reg);
                                         mul_b = 32'(desired_reg); end
            lsts_pkg::MS_WET:      begin mul_a = 25'(wet_c); mul_b = 32'(gain_reg); end
            lsts_pkg::MS_MAG_LO:   begin mul_a = 25'(mag_sel); mul_b = 32'(factor_reg[23:0]); end
            lsts_pkg::MS_MAG_HI:   begin mul_a = 25'(mag_sel); mul_b = 32'(factor_reg[39:24]); end
            default:               begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = 57'(mul_a) * 57'(mul_b);
    end

    always_comb
    begin
        case (cmd.acc)
            lsts_pkg::ACC_LOAD:   acc_next = 64'(prod_reg);
            lsts_pkg::ACC_ADD:    acc_next = acc_reg + 64'(prod_reg);
            lsts_pkg::ACC_ADD_HI: acc_next = acc_reg + (64'(prod_reg) << 24);
            default:              acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        fast_env_next = fast_env_reg;
        slow_env_next = slow_env_reg;
        gain_next     = gain_reg;
        case (cmd.wb)
            lsts_pkg::WB_FAST: fast_env_next = pole_rnd[55:24];
            lsts_pkg::WB_SLOW: slow_env_next = pole_rnd[55:24];
            lsts_pkg::WB_GAIN: gain_next     = pole_rnd[47:24];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg    <= lsts_pkg::RST_ATTACK;
            sustain_reg   <= lsts_pkg::RST_SUSTAIN;
            fast_coef_reg <= lsts_pkg::RST_FAST;
            slow_coef_reg <= lsts_pkg::RST_SLOW;
            slew_coef_reg <= lsts_pkg::RST_SLEW;
            wet_reg       <= lsts_pkg::RST_WET;
            fast_env_reg  <= '0;
            slow_env_reg  <= '0;
            gain_reg      <= lsts_pkg::ONE_Q20;
        end
        else
        begin
            fast_env_reg <= fast_env_next;
            slow_env_reg <= slow_env_next;
            gain_reg     <= gain_next;
            if (cfg_we)
            begin
                case (lsts_pkg::cfg_idx_t'(cfg_index))
                    lsts_pkg::CFG_ATTACK:  attack_reg    <= cfg_data[15:0];
                    lsts_pkg::CFG_SUSTAIN: sustain_reg   <= cfg_data[15:0];
                    lsts_pkg::CFG_FAST:    fast_coef_reg <= cfg_data;
                    lsts_pkg::CFG_SLOW:    slow_coef_reg <= cfg_data;
                    lsts_pkg::CFG_SLEW:    slew_coef_reg <= cfg_data;
                    lsts_pkg::CFG_WET:     wet_reg       <= cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        case (cmd.wb)
            lsts_pkg::WB_CAPTURE:
            begin
                neg_l_reg <= left_in[lsts_pkg::SMP_W-1];
                neg_r_reg <= right_in[lsts_pkg::SMP_W-1];
                mag_l_reg <= mag24(left_in);
                mag_r_reg <= mag24(right_in);
                level_reg <= {mag_sum, 7'b0};
            end
            lsts_pkg::WB_DIV_INIT:
            begin
                denom_reg      <= (slow_env_reg == '0) ? 32'd1 : slow_env_reg;
                attack_sel_reg <= fast_env_reg >= slow_env_reg;
                rem_reg        <= {1'b0, env_diff};
                ratio_reg      <= '0;
            end
            lsts_pkg::WB_DIV_STEP:
            begin
                rem_reg   <= rem_ge ? (rem_shift - {1'b0, denom_reg}) : rem_shift;
                ratio_reg <= {ratio_reg[15:0], rem_ge};
            end
            lsts_pkg::WB_RATIO_SAT: ratio_reg <= lsts_pkg::RATIO_FULL;
            lsts_pkg::WB_TERM:
                term_reg <= $signed(attack_sel_reg ? attack_reg : sustain_reg)
                            * $signed({1'b0, ratio_reg});
            lsts_pkg::WB_DESIRED: desired_reg <= desired_next;
            lsts_pkg::WB_FACTOR:  factor_reg  <= dry_part + 40'(prod_reg);
            lsts_pkg::WB_OUT_L:   res_l_reg   <= shape24(acc_reg, neg_l_reg);
            lsts_pkg::WB_OUT_R:   res_r_reg   <= shape24(acc_reg, neg_r_reg);
            lsts_pkg::WB_PUBLISH:
            begin
                out_l_reg <= res_l_reg;
                out_r_reg <= res_r_reg;
            end
            default: ;
        endcase
    end

    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

    `LSTS_ASSERT_IMP(a_gain_range, 1'b1, (gain_reg >= 24'd209715) && (gain_reg <= 24'd4194304))
    `LSTS_ASSERT_NXT(a_desired_clamped, cmd.wb == lsts_pkg::WB_DESIRED, (desired_reg >= lsts_pkg::GAIN_MIN_Q20) && (desired_reg <= lsts_pkg::GAIN_MAX_Q20))
    `LSTS_ASSERT_NXT(a_ratio_capped, cmd.wb == lsts_pkg::WB_RATIO_SAT, ratio_reg == lsts_pkg::RATIO_FULL)

endmodule

// ----- hdl/lsts_ctrl.sv -----
`include "linked_stereo_transient_shaper_defines.svh"

module lsts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lsts_pkg::status_t status,
    output lsts_pkg::cmd_t    cmd
);

    lsts_pkg::state_t state_reg, state_next;
    logic [lsts_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsts_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        cmd        = '{mul: lsts_pkg::MS_NONE, acc: lsts_pkg::ACC_HOLD,
                       wb: lsts_pkg::WB_NONE, chan: 1'b0};
        in_ready   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            lsts_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wb     = lsts_pkg::WB_CAPTURE;
                    state_next = lsts_pkg::S_F0;
                end
            end
            lsts_pkg::S_F0:
            begin
                cmd.mul = lsts_pkg::MS_FAST_OLD;
                state_next = lsts_pkg::S_F1;
            end
            lsts_pkg::S_F1:
            begin
                cmd.mul = lsts_pkg::MS_FAST_NEW;
                cmd.acc = lsts_pkg::ACC_LOAD;
                state_next = lsts_pkg::S_F2;
            end
            lsts_pkg::S_F2:
            begin
                cmd.mul = lsts_pkg::MS_SLOW_OLD;
                cmd.acc = lsts_pkg::ACC_ADD;
                state_next = lsts_pkg::S_F3;
            end
            lsts_pkg::S_F3:
            begin
                cmd.mul = lsts_pkg::MS_SLOW_NEW;
                cmd.acc = lsts_pkg::ACC_LOAD;
                cmd.wb  = lsts_pkg::WB_FAST;
                state_next = lsts_pkg::S_S1;
            end
            lsts_pkg::S_S1:
            begin
                cmd.acc = lsts_pkg::ACC_ADD;
                state_next = lsts_pkg::S_S2;
            end
            lsts_pkg::S_S2:
            begin
                cmd.wb = lsts_pkg::WB_SLOW;
                state_next = lsts_pkg::S_D0;
            end
            lsts_pkg::S_D0:
            begin
                cmd.wb = lsts_pkg::WB_DIV_INIT;
                state_next = lsts_pkg::S_DIV;
            end
            lsts_pkg::S_DIV:
            begin
                // a difference at least as large as the denominator saturates the ratio
                if (cnt_reg == '0 && status.ratio_sat)
                begin
                    cmd.wb = lsts_pkg::WB_RATIO_SAT;
                    state_next = lsts_pkg::S_T0;
                end
                else
                begin
                    cmd.wb = lsts_pkg::WB_DIV_STEP;
                    if (cnt_reg == lsts_pkg::DCNT_W'(lsts_pkg::DIV_STEPS - 1))
                        state_next = lsts_pkg::S_T0;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            lsts_pkg::S_T0:
            begin
                cmd.wb = lsts_pkg::WB_TERM;
                state_next = lsts_pkg::S_T1;
            end
            lsts_pkg::S_T1:
            begin
                cmd.wb = lsts_pkg::WB_DESIRED;
                state_next = lsts_pkg::S_G0;
            end
            lsts_pkg::S_G0:
            begin
                cmd.mul = lsts_pkg::MS_SLEW_OLD;
                state_next = lsts_pkg::S_G1;
            end
            lsts_pkg::S_G1:
            begin
                cmd.mul = lsts_pkg::MS_SLEW_NEW;
                cmd.acc = lsts_pkg::ACC_LOAD;
                state_next = lsts_pkg::S_G2;
            end
            lsts_pkg::S_G2:
            begin
                cmd.acc = lsts_pkg::ACC_ADD;
                state_next = lsts_pkg::S_G3;
            end
            lsts_pkg::S_G3:
            begin
                cmd.wb = lsts_pkg::WB_GAIN;
                state_next = lsts_pkg::S_W0;
            end
            lsts_pkg::S_W0:
            begin
                cmd.mul = lsts_pkg::MS_WET;
                state_next = lsts_pkg::S_W1;
            end
            lsts_pkg::S_W1:
            begin
                cmd.wb = lsts_pkg::WB_FACTOR;
                state_next = lsts_pkg::S_L0;
            end
            lsts_pkg::S_L0:
            begin
                cmd.mul = lsts_pkg::MS_MAG_LO;
                state_next = lsts_pkg::S_L1;
            end
            lsts_pkg::S_L1:
            begin
                cmd.mul = lsts_pkg::MS_MAG_HI;
                cmd.acc = lsts_pkg::ACC_LOAD;
                state_next = lsts_pkg::S_L2;
            end
            lsts_pkg::S_L2:
            begin
                cmd.mul  = lsts_pkg::MS_MAG_LO;
                cmd.chan = 1'b1;
                cmd.acc  = lsts_pkg::ACC_ADD_HI;
                state_next = lsts_pkg::S_L3;
            end
            lsts_pkg::S_L3:
            begin
                cmd.mul  = lsts_pkg::MS_MAG_HI;
                cmd.chan = 1'b1;
                cmd.acc  = lsts_pkg::ACC_LOAD;
                cmd.wb   = lsts_pkg::WB_OUT_L;
                state_next = lsts_pkg::S_R1;
            end
            lsts_pkg::S_R1:
            begin
                cmd.acc = lsts_pkg::ACC_ADD_HI;
                state_next = lsts_pkg::S_R2;
            end
            lsts_pkg::S_R2:
            begin
                cmd.wb = lsts_pkg::WB_OUT_R;
                state_next = lsts_pkg::S_PUB;
            end
            lsts_pkg::S_PUB:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.wb = lsts_pkg::WB_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next = lsts_pkg::S_IDLE;
                end
            end
            default: state_next = lsts_pkg::S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

    `LSTS_ASSERT_NXT(a_pub_waits, (state_reg == lsts_pkg::S_PUB) && out_valid_reg && !out_ready, state_reg == lsts_pkg::S_PUB)
    `LSTS_ASSERT_IMP(a_cnt_idle, state_reg != lsts_pkg::S_DIV, cnt_reg == '0)
    `LSTS_ASSERT_NXT(a_accept_starts, (state_reg == lsts_pkg::S_IDLE) && in_valid, state_reg == lsts_pkg::S_F0)

endmodule

// ----- hdl/linked_stereo_transient_shaper.sv -----
// Channel    Dir  Beat payload                  Handshake
// frames     in   left_in, right_in (s24)       valid/ready
// shaped     out  left_out, right_out (s24)     valid/ready
// cfg        in   cfg_index, cfg_data           cfg_we, no back-pressure
//
// A frame runs from accept to result with the ratio either saturated at once or
// built by the 16-step restoring divider, all on one shared 25x32 multiplier;
// the input is ready again in the cycle after the result is handed over.
// Reset (rst_n low, asynchronous) restores the register defaults, zeroes both
// envelopes and sets the smoothed gain to unity.
// A finished beat waits in the output register; the next frame is taken
// meanwhile and only stalls at its own hand-over if that beat is still held.
module linked_stereo_transient_shaper (
    input  logic                          clk,
    input  logic                          rst_n,
    lsts_in_if.sink                       frames,
    lsts_out_if.source                    shaped,
    input  logic                          cfg_we,
    input  logic [lsts_pkg::CFG_IX_W-1:0] cfg_index,
    input  logic [lsts_pkg::CFG_W-1:0]    cfg_data
);

    lsts_pkg::cmd_t    cmd;
    lsts_pkg::status_t status;

    // Sequence the frame: envelopes, ratio divide, gain slew, mix.
    lsts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frames.valid),
        .in_ready  (frames.ready),
        .out_valid (shaped.valid),
        .out_ready (shaped.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold configuration, filter state and the arithmetic units.
    lsts_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .left_in   (frames.left_in),
        .right_in  (frames.right_in),
        .left_out  (shaped.left_out),
        .right_out (shaped.right_out)
    );

endmodule
